@@ src/mbda_pkg.sv @@
// Shared types and constants for the multi-button debounce and auto-repeat unit.
// Used by every module under src; depends on nothing else.
package mbda_pkg;

  localparam int PORT_W = 4;
  localparam int PIN_W  = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REP_START    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REP_INTERVAL = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE       = 2'd3;

  // Register values after reset.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd20;
  localparam logic [CFG_W-1:0] REP_START_RST    = 16'd300;
  localparam logic [CFG_W-1:0] REP_INTERVAL_RST = 16'd50;
  localparam logic             ACTIVE_RST       = 1'b0;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SHORT   = 2'd1,
    EV_REPEAT  = 2'd2,
    EV_RELEASE = 2'd3
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] rep_start;
    logic [CFG_W-1:0] rep_interval;
    logic             active;
  } cfg_t;

  // Per-slot press tracking, one word of the slot memory.
  typedef struct packed {
    logic              confirmed;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] repeat_time;
  } slot_entry_t;

  // Result of a key lookup.
  typedef struct packed {
    logic hit;
    logic fresh;
    logic full;
  } lookup_t;

endpackage

@@ src/mbda_key_table.sv @@
// Key table: the (port, pin) binding of every slot, the fill count and the match search.
// Depends on mbda_pkg.
module mbda_key_table #(
  parameter int SLOT_COUNT = 16,
  parameter int IDX_W      = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       match_en,
  input  logic                       bind_en,
  input  logic [mbda_pkg::PORT_W-1:0] key_port,
  input  logic [mbda_pkg::PIN_W-1:0]  key_pin,
  output logic [IDX_W-1:0]           slot_idx,
  output mbda_pkg::lookup_t          lookup
);

  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  // Slots are bound in order and never freed, so slot i is bound exactly
  // when i is below the fill count.
  logic [CNT_W-1:0]            fill_count;
  logic [mbda_pkg::PORT_W-1:0] slot_port [SLOT_COUNT];
  logic [mbda_pkg::PIN_W-1:0]  slot_pin  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]       match;
  logic [IDX_W-1:0]            hit_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (bind_en && lookup.fresh) begin
      fill_count <= fill_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (bind_en && lookup.fresh) begin
      slot_port[fill_count[IDX_W-1:0]] <= key_port;
      slot_pin[fill_count[IDX_W-1:0]]  <= key_pin;
    end
  end

  // One compare per slot, registered before the encode.
  always_ff @(posedge clk) begin
    if (match_en) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        match[i] <= (CNT_W'(i) < fill_count) && (slot_port[i] == key_port) &&
                    (slot_pin[i] == key_pin);
      end
    end
  end

  // Keys are unique, so at most one match bit is set and an OR encode suffices.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign lookup.hit   = |match;
  assign lookup.fresh = !lookup.hit && (fill_count < CNT_W'(SLOT_COUNT));
  assign lookup.full  = !lookup.hit && !lookup.fresh;
  assign slot_idx     = lookup.hit ? hit_idx : fill_count[IDX_W-1:0];

endmodule

@@ src/mbda_slot_mem.sv @@
// Slot memory: press tracking words, one write and one registered read port.
// Depends on mbda_pkg.
module mbda_slot_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  mbda_pkg::slot_entry_t wdata,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr,
  output mbda_pkg::slot_entry_t rdata
);

  mbda_pkg::slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/mbda_event_calc.sv @@
// Debounce and auto-repeat decision for one slot: event and updated tracking word.
// Depends on mbda_pkg.
module mbda_event_calc (
  input  mbda_pkg::slot_entry_t      cur,
  input  logic                       fresh,
  input  logic                       down,
  input  logic [mbda_pkg::TIME_W-1:0] now,
  input  mbda_pkg::cfg_t             cfg,
  output mbda_pkg::event_t           ev,
  output mbda_pkg::slot_entry_t      upd
);

  mbda_pkg::slot_entry_t           entry;
  logic [mbda_pkg::TIME_W-1:0]     since_press;
  logic [mbda_pkg::TIME_W-1:0]     since_repeat;

  // A slot just bound has never been written and starts from the reset word.
  assign entry        = fresh ? '0 : cur;
  assign since_press  = now - entry.press_time;
  assign since_repeat = now - entry.repeat_time;

  always_comb begin
    upd = entry;
    ev  = mbda_pkg::EV_NONE;
    if (!down) begin
      upd.confirmed  = 1'b0;
      upd.press_time = '0;
      ev             = mbda_pkg::EV_RELEASE;
    end else if (!entry.confirmed) begin
      // A press time of zero means no press is pending.
      if (entry.press_time == '0) begin
        upd.press_time = now;
      end else if (since_press >= {16'd0, cfg.debounce}) begin
        upd.confirmed   = 1'b1;
        upd.press_time  = now;
        upd.repeat_time = now;
        ev              = mbda_pkg::EV_SHORT;
      end
    end else if ((since_press >= {16'd0, cfg.rep_start}) &&
                 (since_repeat >= {16'd0, cfg.rep_interval})) begin
      upd.repeat_time = now;
      ev              = mbda_pkg::EV_REPEAT;
    end
  end

endmodule

@@ src/multi_button_debounce_autorepeat_unit.sv @@
// Multi-button debounce and auto-repeat unit, top level; uses mbda_pkg, mbda_key_table,
// mbda_slot_mem and mbda_event_calc. An item passes the MATCH, FIND and EXEC states, and
// its result is then loaded into the output register. The match, encode and memory
// read-modify-write sequence handles one item at a time; an item is taken while a
// result still waits. Reset (rst, synchronous) frees all slots, restores the register
// defaults and empties the output register. The slot memory needs no clearing pass.
module multi_button_debounce_autorepeat_unit #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_wr_en,
  input  logic [mbda_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbda_pkg::CFG_W-1:0]    cfg_data,
  // Sample channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mbda_pkg::PORT_W-1:0]   port_id,
  input  logic [mbda_pkg::PIN_W-1:0]    pin_mask,
  input  logic                          pin_level,
  input  logic [mbda_pkg::TIME_W-1:0]   now_ms,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    event_res,
  output logic                          table_full,
  output logic                          pressed_pulse,
  output logic                          clicked
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // The sequencer walks each item through four steps:
  //   IDLE  - wait for and capture an item,
  //   MATCH - compare the item's key against all bound slots,
  //   FIND  - pick the matching slot or bind a new one, and read its memory word,
  //   EXEC  - decide the event, write the word back and load the output register.
  // EXEC waits only when the output register still holds an untaken result.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_FIND  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

  state_t state, state_next;

  mbda_pkg::cfg_t cfg;

  logic [mbda_pkg::PORT_W-1:0] port_q;
  logic [mbda_pkg::PIN_W-1:0]  pin_q;
  logic                        level_q;
  logic [mbda_pkg::TIME_W-1:0] now_q;

  logic [IDX_W-1:0]      slot_idx;
  logic [IDX_W-1:0]      slot_idx_q;
  mbda_pkg::lookup_t     lookup;
  mbda_pkg::lookup_t     lookup_q;

  mbda_pkg::slot_entry_t rd_entry;
  mbda_pkg::slot_entry_t wr_entry;
  mbda_pkg::event_t      ev;

  logic in_take;
  logic out_load;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  // The output register can be loaded when it is empty or being emptied now.
  assign out_load = (state == ST_EXEC) && (!out_valid || !out_stall);

  // Configuration registers; every index of the port maps to a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce     <= mbda_pkg::DEBOUNCE_RST;
      cfg.rep_start    <= mbda_pkg::REP_START_RST;
      cfg.rep_interval <= mbda_pkg::REP_INTERVAL_RST;
      cfg.active       <= mbda_pkg::ACTIVE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mbda_pkg::CFG_DEBOUNCE:     cfg.debounce     <= cfg_data;
        mbda_pkg::CFG_REP_START:    cfg.rep_start    <= cfg_data;
        mbda_pkg::CFG_REP_INTERVAL: cfg.rep_interval <= cfg_data;
        mbda_pkg::CFG_ACTIVE:       cfg.active       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_take) begin
        state_next = ST_MATCH;
      end
      ST_MATCH: state_next = ST_FIND;
      ST_FIND:  state_next = ST_EXEC;
      ST_EXEC:  if (out_load) begin
        state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Captured sample fields.
  always_ff @(posedge clk) begin
    if (in_take) begin
      port_q  <= port_id;
      pin_q   <= pin_mask;
      level_q <= pin_level;
      now_q   <= now_ms;
    end
  end

  // Lookup outcome, held for the write-back in EXEC.
  always_ff @(posedge clk) begin
    if (state == ST_FIND) begin
      slot_idx_q <= slot_idx;
      lookup_q   <= lookup;
    end
  end

  mbda_key_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_key_table (
    .clk      (clk),
    .rst      (rst),
    .match_en (state == ST_MATCH),
    .bind_en  (state == ST_FIND),
    .key_port (port_q),
    .key_pin  (pin_q),
    .slot_idx (slot_idx),
    .lookup   (lookup)
  );

  // The word of an item's slot is read in FIND and written back in EXEC; with one
  // item in flight a read never meets a pending write to the same slot.
  mbda_slot_mem #(
    .DEPTH  (SLOT_COUNT),
    .ADDR_W (IDX_W)
  ) u_slot_mem (
    .clk   (clk),
    .we    (out_load && !lookup_q.full),
    .waddr (slot_idx_q),
    .wdata (wr_entry),
    .re    (state == ST_FIND),
    .raddr (slot_idx),
    .rdata (rd_entry)
  );

  mbda_event_calc u_event_calc (
    .cur   (rd_entry),
    .fresh (lookup_q.fresh),
    .down  (level_q == cfg.active),
    .now   (now_q),
    .cfg   (cfg),
    .ev    (ev),
    .upd   (wr_entry)
  );

  // Output register. A full table leaves every slot untouched and reports no event.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (lookup_q.full) begin
        event_res     <= mbda_pkg::EV_NONE;
        table_full    <= 1'b1;
        pressed_pulse <= 1'b0;
        clicked       <= 1'b0;
      end else begin
        event_res     <= ev;
        table_full    <= 1'b0;
        pressed_pulse <= (ev == mbda_pkg::EV_SHORT) || (ev == mbda_pkg::EV_REPEAT);
        clicked       <= (ev == mbda_pkg::EV_SHORT);
      end
    end
  end

endmodule

@@ src/mbda_checker.sv @@
// Port-level checker for the multi-button debounce and auto-repeat unit, with its bind.
// Depends on mbda_pkg and multi_button_debounce_autorepeat_unit.
module mbda_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] event_res,
  input logic       table_full,
  input logic       pressed_pulse,
  input logic       clicked
);

  // The pulse flag follows the event code.
  a_pulse_matches_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pressed_pulse == ((event_res == mbda_pkg::EV_SHORT) ||
                                     (event_res == mbda_pkg::EV_REPEAT))))
    else $error("pressed_pulse disagrees with event_res");

  a_click_matches_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (clicked == (event_res == mbda_pkg::EV_SHORT)))
    else $error("clicked disagrees with event_res");

  // A full table never reports an event.
  a_full_no_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (event_res == mbda_pkg::EV_NONE))
    else $error("event reported with table full");

  // One item at a time: the block is busy right after it takes an item.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item taken while the previous one is in progress");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(event_res) && $stable(table_full)))
    else $error("stalled result changed");

endmodule

bind multi_button_debounce_autorepeat_unit mbda_checker u_mbda_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .event_res     (event_res),
  .table_full    (table_full),
  .pressed_pulse (pressed_pulse),
  .clicked       (clicked)
);

@@ verif/multi_button_debounce_autorepeat_unit_tb.sv @@
// Self-checking testbench for multi_button_debounce_autorepeat_unit: button samples go in
// through the valid/stall channel and every result is checked against a slot-table predictor.
// Depends on mbda_pkg and the unit RTL under src.
module multi_button_debounce_autorepeat_unit_tb;

  localparam int SLOTS = 16;
  localparam int HALF_PERIOD = 6;
  localparam int MAX_WAIT = 17;
  localparam int POOL = 10;
  localparam int PHASE_ITEMS = 190;
  localparam int DRAIN_LIMIT = 2000;
  localparam int TIMEOUT_CYCLES = 1000000;

  // One button sample as it travels on the input channel.
  typedef struct {
    logic [mbda_pkg::PORT_W-1:0] port;
    logic [mbda_pkg::PIN_W-1:0]  pin;
    logic                        level;
    logic [mbda_pkg::TIME_W-1:0] now;
  } sample_t;

  // The outcome the unit reports for one sample.
  typedef struct {
    mbda_pkg::event_t ev;
    logic             full;
    logic             pulse;
    logic             click;
  } button_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_wr_en = 1'b0;
  logic [mbda_pkg::CFG_INDEX_W-1:0] cfg_index = mbda_pkg::CFG_DEBOUNCE;
  logic [mbda_pkg::CFG_W-1:0]       cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [mbda_pkg::PORT_W-1:0]      port_id = '0;
  logic [mbda_pkg::PIN_W-1:0]       pin_mask = '0;
  logic                             pin_level = 1'b0;
  logic [mbda_pkg::TIME_W-1:0]      now_ms = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [1:0]                       event_res;
  logic                             table_full;
  logic                             pressed_pulse;
  logic                             clicked;

  multi_button_debounce_autorepeat_unit #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .port_id(port_id),
    .pin_mask(pin_mask),
    .pin_level(pin_level),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_res(event_res),
    .table_full(table_full),
    .pressed_pulse(pressed_pulse),
    .clicked(clicked)
  );

  // The clock toggles every half period, giving a period of 12 time units.
  always #(HALF_PERIOD) clk = ~clk;

  // Predictor state: a private copy of the slot table and of the register settings.
  logic                        key_bound   [SLOTS];
  logic [mbda_pkg::PORT_W-1:0] key_port    [SLOTS];
  logic [mbda_pkg::PIN_W-1:0]  key_pin     [SLOTS];
  logic [mbda_pkg::TIME_W-1:0] down_since  [SLOTS];
  logic [mbda_pkg::TIME_W-1:0] last_repeat [SLOTS];
  logic                        held        [SLOTS];
  mbda_pkg::cfg_t              model_cfg;

  // Samples waiting to be driven, and outcomes waiting for the unit to report them.
  sample_t        pending_samples[$];
  button_result_t expected_events[$];

  // Handshake flags, refreshed at every rising edge by the monitor and read at the
  // following falling edge by the drivers.
  bit sample_taken = 1'b0;
  bit result_taken = 1'b0;

  int send_gap = 0;
  int hold_left = 0;
  int send_wait_max = MAX_WAIT;
  int stall_wait_max = MAX_WAIT;
  int fail_count = 0;
  int queued_total = 0;

  // Stimulus time base and the set of buttons that the random part presses.
  logic [mbda_pkg::TIME_W-1:0] clock_ms = '0;
  logic [mbda_pkg::PORT_W-1:0] pool_port [POOL];
  logic [mbda_pkg::PIN_W-1:0]  pool_pin  [POOL];

  // Works out the outcome of one sample and advances the predictor's slot table.
  // A valid slot bound to the same port and pin wins; otherwise the lowest free slot
  // is bound. With no slot at all the table is full and nothing changes.
  function automatic button_result_t debounce_sample(sample_t s);
    button_result_t r;
    int slot;
    logic [mbda_pkg::TIME_W-1:0] since_press;
    logic [mbda_pkg::TIME_W-1:0] since_repeat;
    r.ev = mbda_pkg::EV_NONE;
    r.full = 1'b0;
    slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot < 0 && key_bound[i] && key_port[i] == s.port && key_pin[i] == s.pin)
        slot = i;
    end
    if (slot < 0) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!key_bound[i])
          slot = i;
      end
      if (slot >= 0) begin
        key_bound[slot] = 1'b1;
        key_port[slot] = s.port;
        key_pin[slot] = s.pin;
      end
    end
    if (slot < 0) begin
      r.full = 1'b1;
    end else begin
      since_press = s.now - down_since[slot];
      since_repeat = s.now - last_repeat[slot];
      if (s.level != model_cfg.active) begin
        // Any released sample drops the press and reports a release.
        held[slot] = 1'b0;
        down_since[slot] = '0;
        r.ev = mbda_pkg::EV_RELEASE;
      end else if (!held[slot]) begin
        // A press start of zero means no press is pending yet.
        if (down_since[slot] == '0) begin
          down_since[slot] = s.now;
        end else if (since_press >= mbda_pkg::TIME_W'(model_cfg.debounce)) begin
          held[slot] = 1'b1;
          down_since[slot] = s.now;
          last_repeat[slot] = s.now;
          r.ev = mbda_pkg::EV_SHORT;
        end
      end else if (since_press >= mbda_pkg::TIME_W'(model_cfg.rep_start) &&
                   since_repeat >= mbda_pkg::TIME_W'(model_cfg.rep_interval)) begin
        last_repeat[slot] = s.now;
        r.ev = mbda_pkg::EV_REPEAT;
      end
    end
    r.pulse = (r.ev == mbda_pkg::EV_SHORT || r.ev == mbda_pkg::EV_REPEAT);
    r.click = (r.ev == mbda_pkg::EV_SHORT);
    return r;
  endfunction

  // Every failure goes through here and is printed.
  task automatic log_fail(string msg);
    fail_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic queue_sample(logic [mbda_pkg::PORT_W-1:0] port,
                              logic [mbda_pkg::PIN_W-1:0] pin,
                              logic level, logic [mbda_pkg::TIME_W-1:0] now);
    sample_t s;
    s = '{port, pin, level, now};
    pending_samples.push_back(s);
    queued_total++;
  endtask

  // One press of pool button k: a run of samples at the active level with the odd
  // bounce, samples of other buttons mixed in, and a release at the end. The time
  // step scales with the current settings so that confirmation and repeats are reached.
  task automatic queue_hold(int k, int steps);
    int span;
    int j;
    logic down;
    span = int'(model_cfg.debounce) / 4 + int'(model_cfg.rep_start) / 8 +
           int'(model_cfg.rep_interval) / 2 + 4;
    down = model_cfg.active;
    for (int n = 0; n < steps; n++) begin
      clock_ms += $urandom_range(0, span);
      if ($urandom_range(0, 5) == 0) begin
        j = $urandom_range(0, POOL - 1);
        queue_sample(pool_port[j], pool_pin[j], 1'($urandom), clock_ms);
      end else begin
        queue_sample(pool_port[k], pool_pin[k],
                     ($urandom_range(0, 11) == 0) ? !down : down, clock_ms);
      end
    end
    clock_ms += $urandom_range(0, span);
    queue_sample(pool_port[k], pool_pin[k], !down, clock_ms);
  endtask

  // Drives one register write; the enable stays high for the next write or is
  // dropped by the caller.
  task automatic put_reg(logic [mbda_pkg::CFG_INDEX_W-1:0] index,
                         logic [mbda_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
  endtask

  // Writes all four registers back to back and mirrors them into the predictor.
  task automatic apply_settings(mbda_pkg::cfg_t next_cfg);
    logic [mbda_pkg::CFG_W-1:0] level_word;
    // Only bit 0 of the level register counts, so the upper data bits carry noise.
    level_word = mbda_pkg::CFG_W'($urandom);
    level_word[0] = next_cfg.active;
    put_reg(mbda_pkg::CFG_DEBOUNCE, next_cfg.debounce);
    put_reg(mbda_pkg::CFG_REP_START, next_cfg.rep_start);
    put_reg(mbda_pkg::CFG_REP_INTERVAL, next_cfg.rep_interval);
    put_reg(mbda_pkg::CFG_ACTIVE, level_word);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_cfg = next_cfg;
  endtask

  // Waits until every queued sample is taken and every outcome has come back.
  // If nothing moves for a long time the wait gives up and the leftovers fail the run.
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while ((pending_samples.size() != 0 || in_valid || expected_events.size() != 0) &&
           quiet < DRAIN_LIMIT) begin
      @(negedge clk);
      if (sample_taken || result_taken)
        quiet = 0;
      else
        quiet++;
    end
    if (expected_events.size() != 0)
      log_fail($sformatf("%0d outcomes never reported", expected_events.size()));
  endtask

  // Sample driver. Inputs change at the falling edge. After each accepted item it
  // idles for a drawn number of cycles; with a zero draw the next item follows
  // straight away and valid stays high.
  always @(negedge clk) begin : drive_samples
    sample_t s;
    if (in_valid && sample_taken)
      send_gap = $urandom_range(0, send_wait_max);
    if (!in_valid || sample_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        s = pending_samples.pop_front();
        in_valid <= 1'b1;
        port_id <= s.port;
        pin_mask <= s.pin;
        pin_level <= s.level;
        now_ms <= s.now;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back pressure. After each accepted result the receiver stalls for a
  // drawn number of cycles, so the stall can land on any cycle of the unit's work.
  always @(negedge clk) begin : drive_stall
    if (result_taken)
      hold_left = $urandom_range(0, stall_wait_max);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor. At each rising edge it notes both handshakes, checks an accepted result
  // against the oldest outcome still waiting, and predicts the outcome of an
  // accepted sample.
  always @(posedge clk) begin : watch_channels
    button_result_t want;
    sample_t seen;
    sample_taken = !rst && in_valid && !in_stall;
    result_taken = !rst && out_valid && !out_stall;
    if (result_taken) begin
      if (expected_events.size() == 0) begin
        log_fail($sformatf("result with no item outstanding, expected none, actual event %0d full %0d",
                           event_res, table_full));
      end else begin
        want = expected_events.pop_front();
        if (event_res !== want.ev)
          log_fail($sformatf("event_res expected %0d actual %0d", want.ev, event_res));
        if (table_full !== want.full)
          log_fail($sformatf("table_full expected %0d actual %0d", want.full, table_full));
        if (pressed_pulse !== want.pulse)
          log_fail($sformatf("pressed_pulse expected %0d actual %0d", want.pulse, pressed_pulse));
        if (clicked !== want.click)
          log_fail($sformatf("clicked expected %0d actual %0d", want.click, clicked));
      end
    end
    if (sample_taken) begin
      seen = '{port_id, pin_mask, pin_level, now_ms};
      expected_events.push_back(debounce_sample(seen));
    end
  end

  // Main sequence: reset, a directed run on the reset settings, then phases of random
  // presses under different settings, ending with a phase that fills the slot table.
  initial begin : run_test
    mbda_pkg::cfg_t next_cfg;
    int goal;
    model_cfg = '{mbda_pkg::DEBOUNCE_RST, mbda_pkg::REP_START_RST,
                  mbda_pkg::REP_INTERVAL_RST, mbda_pkg::ACTIVE_RST};
    for (int i = 0; i < SLOTS; i++) begin
      key_bound[i] = 1'b0;
      key_port[i] = '0;
      key_pin[i] = '0;
      down_since[i] = '0;
      last_repeat[i] = '0;
      held[i] = 1'b0;
    end
    for (int k = 0; k < POOL; k++) begin
      pool_port[k] = mbda_pkg::PORT_W'($urandom);
      pool_pin[k] = mbda_pkg::PIN_W'(1) << $urandom_range(0, mbda_pkg::PIN_W - 1);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items on the reset settings: pressed is level 0, 20 ms debounce,
    // repeats from 300 ms on, 50 ms apart.
    // A press first seen at time zero stays unpending; the next sample starts it.
    queue_sample(4'hF, 16'h8000, 1'b0, 32'd0);
    queue_sample(4'hF, 16'h8000, 1'b0, 32'd25);
    // One short of and exactly at the debounce time.
    queue_sample(4'hF, 16'h8000, 1'b0, 32'd44);
    queue_sample(4'hF, 16'h8000, 1'b0, 32'd45);
    // Around the repeat start and the repeat interval.
    queue_sample(4'hF, 16'h8000, 1'b0, 32'd344);
    queue_sample(4'hF, 16'h8000, 1'b0, 32'd345);
    queue_sample(4'hF, 16'h8000, 1'b0, 32'd394);
    queue_sample(4'hF, 16'h8000, 1'b0, 32'd395);
    // Release after a confirmed press, then again with nothing pressed.
    queue_sample(4'hF, 16'h8000, 1'b1, 32'd400);
    queue_sample(4'hF, 16'h8000, 1'b1, 32'd401);
    // A new button whose first sample is a release, then a press across the time wrap.
    queue_sample(4'h0, 16'h0001, 1'b1, 32'hFFFF_FFFF);
    queue_sample(4'h0, 16'h0001, 1'b0, 32'hFFFF_FFF0);
    queue_sample(4'h0, 16'h0001, 1'b0, 32'h0000_0003);
    queue_sample(4'h0, 16'h0001, 1'b0, 32'h0000_0004);
    queue_sample(4'h0, 16'h0001, 1'b0, 32'h0000_0130);
    // An all-zero pin with a bounce that drops the pending press.
    queue_sample(4'h5, 16'h0000, 1'b0, 32'd7);
    queue_sample(4'h5, 16'h0000, 1'b1, 32'd8);
    queue_sample(4'h5, 16'h0000, 1'b0, 32'd9);
    queue_sample(4'h5, 16'h0000, 1'b0, 32'd29);
    // An all-ones pin with a plain press.
    queue_sample(4'hA, 16'hFFFF, 1'b0, 32'd100);
    queue_sample(4'hA, 16'hFFFF, 1'b0, 32'd120);
    clock_ms = 32'd1000;

    for (int phase = 1; phase <= 9; phase++) begin
      wait_idle();
      // Every sample yields a result, so the unit is idle once the last one is in;
      // the extra wait below is only a margin.
      repeat (4) @(posedge clk);
      send_wait_max = (phase % 3 == 1) ? 0 : MAX_WAIT;
      stall_wait_max = (phase % 2 == 1) ? 0 : MAX_WAIT;
      case (phase)
        1: next_cfg = model_cfg;
        2: next_cfg = '{16'd0, 16'd0, 16'd0, 1'b1};
        3: next_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
        4: next_cfg = '{16'd3, 16'd40, 16'd7, 1'b1};
        5: next_cfg = '{16'($urandom_range(0, 60)), 16'($urandom_range(0, 400)),
                        16'($urandom_range(0, 80)), 1'($urandom)};
        6: next_cfg = '{16'd0, 16'hFFFF, 16'd0, 1'b0};
        7: next_cfg = '{16'hFFFF, 16'd0, 16'hFFFF, 1'b1};
        8: next_cfg = '{16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)};
        default: next_cfg = '{16'($urandom_range(0, 40)), 16'($urandom_range(0, 300)),
                               16'($urandom_range(0, 60)), 1'($urandom)};
      endcase
      apply_settings(next_cfg);
      // Long repeat start with the time base just below the wrap point.
      if (phase == 6)
        clock_ms = 32'hFFFF_0000;
      if (phase < 9) begin
        goal = queued_total + PHASE_ITEMS;
        while (queued_total < goal)
          queue_hold($urandom_range(0, POOL - 1), $urandom_range(1, 30));
      end else begin
        // Buttons never seen before use up the free slots; once none is left they
        // report a full table, while the bound buttons keep working.
        for (int n = 0; n < 24; n++) begin
          clock_ms += $urandom_range(0, 50);
          queue_sample(mbda_pkg::PORT_W'($urandom), mbda_pkg::PIN_W'($urandom),
                       1'($urandom), clock_ms);
          queue_hold($urandom_range(0, POOL - 1), $urandom_range(1, 10));
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
